>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fan curve checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define FC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define FC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fc_pkg.sv
// ----------------------------------------------------------------------------
// Fan curve package
// Widths, register indexes, reset values and word types of the fan curve.
// ----------------------------------------------------------------------------
package fc_pkg;

	localparam int TEMP_W     = 7;
	localparam int SPEED_W    = 7;
	localparam int SLOPE_W    = 14;
	localparam int PROD_W     = TEMP_W + SLOPE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// Divide by 100 as a reciprocal multiply on a clamped product.
	localparam int DIV_SHIFT  = 20;
	localparam int CLAMP_W    = 14;
	localparam int QUOT_W     = 7;
	localparam logic [CLAMP_W-1:0] PROD_CLAMP = CLAMP_W'(100 * 101);
	localparam logic [CLAMP_W-1:0] DIV_RECIP  = CLAMP_W'(((1 << DIV_SHIFT) + 99) / 100);

	localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);

	localparam logic [TEMP_W-1:0]  RST_TEMP_LOW   = TEMP_W'(55);
	localparam logic [TEMP_W-1:0]  RST_TEMP_HIGH  = TEMP_W'(80);
	localparam logic [SPEED_W-1:0] RST_FAN_LOW    = SPEED_W'(40);
	localparam logic [SPEED_W-1:0] RST_FAN_HIGH   = SPEED_W'(100);
	localparam logic [SLOPE_W-1:0] RST_SLOPE      = SLOPE_W'(240);
	localparam logic [TEMP_W-1:0]  RST_HYSTERESIS = TEMP_W'(2);
	localparam logic [TEMP_W-1:0]  RST_FAST_DELTA = TEMP_W'(5);
	localparam logic [TEMP_W-1:0]  RST_LAST_TEMP  = TEMP_W'(0);
	localparam logic [SPEED_W-1:0] RST_LAST_FAN   = SPEED_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEMP_LOW   = 3'd0,
		CFG_TEMP_HIGH  = 3'd1,
		CFG_FAN_LOW    = 3'd2,
		CFG_FAN_HIGH   = 3'd3,
		CFG_SLOPE      = 3'd4,
		CFG_HYSTERESIS = 3'd5,
		CFG_FAST_DELTA = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic              sample_valid;
		logic [TEMP_W-1:0] temperature;
	} smp_t;

	typedef struct packed {
		logic               set_fan;
		logic [SPEED_W-1:0] fan_speed;
		logic               fast_poll;
	} cmd_t;

	typedef struct packed {
		logic [TEMP_W-1:0]  temp_low;
		logic [TEMP_W-1:0]  temp_high;
		logic [SPEED_W-1:0] fan_low;
		logic [SPEED_W-1:0] fan_high;
		logic [SLOPE_W-1:0] slope_x100;
		logic [TEMP_W-1:0]  hysteresis;
		logic [TEMP_W-1:0]  fast_delta;
	} cfg_t;

	// Curve segment pick and raw product, handed from mapping to decision.
	typedef struct packed {
		logic              is_low;
		logic              is_high;
		logic              sample_valid;
		logic [TEMP_W-1:0] temperature;
		logic [PROD_W-1:0] product;
	} map_t;

endpackage

>>> src/fc_cfg.sv
// ----------------------------------------------------------------------------
// Fan curve configuration registers
// Holds the seven curve and hysteresis settings written through the cfg port.
// ----------------------------------------------------------------------------
module fc_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [fc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output fc_pkg::cfg_t                   cfg
);

	fc_pkg::cfg_t cfg_q;
	logic [fc_pkg::TEMP_W-1:0] data7;

	assign data7 = cfg_data[fc_pkg::TEMP_W-1:0];
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_low   <= fc_pkg::RST_TEMP_LOW;
			cfg_q.temp_high  <= fc_pkg::RST_TEMP_HIGH;
			cfg_q.fan_low    <= fc_pkg::RST_FAN_LOW;
			cfg_q.fan_high   <= fc_pkg::RST_FAN_HIGH;
			cfg_q.slope_x100 <= fc_pkg::RST_SLOPE;
			cfg_q.hysteresis <= fc_pkg::RST_HYSTERESIS;
			cfg_q.fast_delta <= fc_pkg::RST_FAST_DELTA;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fc_pkg::CFG_TEMP_LOW:   cfg_q.temp_low   <= data7;
				fc_pkg::CFG_TEMP_HIGH:  cfg_q.temp_high  <= data7;
				fc_pkg::CFG_FAN_LOW:    cfg_q.fan_low    <= data7;
				fc_pkg::CFG_FAN_HIGH:   cfg_q.fan_high   <= data7;
				fc_pkg::CFG_SLOPE:      cfg_q.slope_x100 <= cfg_data[fc_pkg::SLOPE_W-1:0];
				fc_pkg::CFG_HYSTERESIS: cfg_q.hysteresis <= data7;
				fc_pkg::CFG_FAST_DELTA: cfg_q.fast_delta <= data7;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

endmodule

>>> src/fc_map.sv
// ----------------------------------------------------------------------------
// Fan curve mapping stage
// Picks the curve segment and forms the slope product for one sample.
// ----------------------------------------------------------------------------
module fc_map (
	input  logic          clk,
	input  logic          load,
	input  fc_pkg::smp_t  smp_s1,
	input  fc_pkg::cfg_t  cfg,
	output fc_pkg::map_t  map_s2
);

	fc_pkg::map_t map_d;
	logic [fc_pkg::TEMP_W-1:0] rise;

	always_comb begin
		rise               = smp_s1.temperature - cfg.temp_low;
		map_d.is_low       = smp_s1.temperature <= cfg.temp_low;
		map_d.is_high      = smp_s1.temperature >= cfg.temp_high;
		map_d.sample_valid = smp_s1.sample_valid;
		map_d.temperature  = smp_s1.temperature;
		map_d.product      = fc_pkg::PROD_W'(rise) * fc_pkg::PROD_W'(cfg.slope_x100);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			map_s2 <= map_d;
		end
	end

endmodule

>>> src/fc_decide.sv
// ----------------------------------------------------------------------------
// Fan curve decision stage
// Scales the product to a speed, applies hysteresis and keeps the last command.
// ----------------------------------------------------------------------------
module fc_decide (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          commit,
	input  fc_pkg::map_t  map_s2,
	input  fc_pkg::cfg_t  cfg,
	output fc_pkg::cmd_t  res
);

	logic [fc_pkg::TEMP_W-1:0]           last_temp_q;
	logic [fc_pkg::SPEED_W-1:0]          last_fan_q;
	logic [fc_pkg::TEMP_W-1:0]           diff;
	logic [fc_pkg::CLAMP_W-1:0]          prod_c;
	logic [2*fc_pkg::CLAMP_W-1:0]        recip_prod;
	logic [fc_pkg::QUOT_W-1:0]           quot;
	logic [fc_pkg::SPEED_W:0]            raw;
	logic [fc_pkg::SPEED_W-1:0]          speed;
	logic                                issue;

	always_comb begin
		diff = (last_temp_q > map_s2.temperature) ? last_temp_q - map_s2.temperature
		                                          : map_s2.temperature - last_temp_q;

		// Quotients past 100 saturate anyway, so clamp before the divide.
		if (map_s2.product > fc_pkg::PROD_W'(fc_pkg::PROD_CLAMP)) begin
			prod_c = fc_pkg::PROD_CLAMP;
		end else begin
			prod_c = map_s2.product[fc_pkg::CLAMP_W-1:0];
		end
		recip_prod = (2*fc_pkg::CLAMP_W)'(prod_c) * (2*fc_pkg::CLAMP_W)'(fc_pkg::DIV_RECIP);
		quot       = recip_prod[fc_pkg::DIV_SHIFT +: fc_pkg::QUOT_W];

		priority if (map_s2.is_low) begin
			raw = {1'b0, cfg.fan_low};
		end else if (map_s2.is_high) begin
			raw = {1'b0, cfg.fan_high};
		end else begin
			raw = {1'b0, cfg.fan_low} + {1'b0, quot};
		end
		speed = (raw > {1'b0, fc_pkg::SPEED_MAX}) ? fc_pkg::SPEED_MAX
		                                          : raw[fc_pkg::SPEED_W-1:0];

		issue = map_s2.sample_valid && (diff >= cfg.hysteresis) && (speed != last_fan_q);

		res.set_fan   = issue;
		res.fan_speed = issue ? speed : '0;
		res.fast_poll = map_s2.sample_valid && (diff > cfg.fast_delta);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q <= fc_pkg::RST_LAST_TEMP;
			last_fan_q  <= fc_pkg::RST_LAST_FAN;
		end else if (commit && issue) begin
			last_temp_q <= map_s2.temperature;
			last_fan_q  <= speed;
		end
	end

endmodule

>>> src/fan_curve_with_hysteresis_top.sv
// ----------------------------------------------------------------------------
// Fan curve with hysteresis, top level
// Three-register pipeline: sample register, curve map, hysteresis decision.
// ----------------------------------------------------------------------------
// Path: a sample accepted into smp_s1 moves through map_s2 into the output
//   register that raises cmd_valid. Throughput: one word per cycle while
//   no held command stalls the pipe; the slope multiply sits before the s2
//   register and the reciprocal divide, saturate and state update after it.
// Reset: clears the valid bits, restores all settings to their defaults and
//   sets last_temp to 0 and last_fan to 1. cfg_ready is always high.
module fan_curve_with_hysteresis_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           smp_valid,
	output logic                           smp_ready,
	input  fc_pkg::smp_t                   smp,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output fc_pkg::cmd_t                   cmd,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [fc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	fc_pkg::cfg_t cfg;
	fc_pkg::smp_t smp_s1;
	fc_pkg::map_t map_s2;
	fc_pkg::cmd_t res;
	fc_pkg::cmd_t cmd_q;
	logic         v_s1;
	logic         v_s2;
	logic         cmd_valid_q;
	logic         en_out;
	logic         en_s2;
	logic         en_s1;

	// Each stage advances when it is empty or the stage after it advances,
	// so bubbles collapse; a held command stalls the sample side only once
	// every stage holds a word.
	assign en_out    = !cmd_valid_q || cmd_ready;
	assign en_s2     = !v_s2 || en_out;
	assign en_s1     = !v_s1 || en_s2;
	assign smp_ready = en_s1;
	assign cfg_ready = 1'b1;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	fc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage 1: hold the accepted sample word.
	always_ff @(posedge clk) begin
		if (en_s1 && smp_valid) begin
			smp_s1 <= smp;
		end
	end

	// Stage 2: segment pick and slope product.
	fc_map u_map (
		.clk    (clk),
		.load   (en_s2 && v_s1),
		.smp_s1 (smp_s1),
		.cfg    (cfg),
		.map_s2 (map_s2)
	);

	// Decision: state updates only when the word moves into the output register.
	fc_decide u_decide (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (en_out && v_s2),
		.map_s2 (map_s2),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= smp_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				cmd_valid_q <= v_s2;
			end
		end
	end

	// Output register: hold the command word until it is taken.
	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			cmd_q <= res;
		end
	end

endmodule

>>> src/fc_chk.sv
// ----------------------------------------------------------------------------
// Fan curve port checker
// Watches the top level ports for command word and reset behavior.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input fc_pkg::cmd_t                   cmd
);

	`FC_ASSERT(a_speed_max, clk, arst_n, cmd_valid && cmd.set_fan |-> cmd.fan_speed <= fc_pkg::SPEED_MAX, "commanded speed above maximum")
	`FC_ASSERT(a_idle_speed, clk, arst_n, cmd_valid && !cmd.set_fan |-> cmd.fan_speed == '0, "speed nonzero without a command")
	`FC_ASSERT(a_cmd_hold, clk, arst_n, cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd), "stalled command word changed")
	`FC_ASSERT_ALWAYS(a_reset_empty, clk, $past(!arst_n) |-> !cmd_valid, "command word valid right after reset")

endmodule

bind fan_curve_with_hysteresis_top fc_chk u_fc_chk (.*);
